// ===== design/pilt_pkg.sv =====
// pilt_pkg: shared widths, operation and status codes, controller states and
// the command / status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pilt_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int NUM_W    = 64;
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_STORE   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_QUERY   = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_FREE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_STORE,
    S_RELEASE,
    S_QSCAN,
    S_QDRAIN,
    S_QFALLBACK,
    S_QCLAMP,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic scan_clr;
    logic scan_inc;
    logic store_try;
    logic rel;
    logic q_read;
    logic fallback;
    logic clamp;
    logic load_out;
  } pilt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_last;
    logic slot_free;
    logic out_busy;
  } pilt_stat_t;

endpackage

// ===== design/pilt_ifs.sv =====
// pilt_in_if / pilt_out_if: valid-ready channels for request and result
// transactions. Depends on pilt_pkg.
`timescale 1ns / 1ps

interface pilt_in_if;
  import pilt_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [NUM_W-1:0] trx_number;
  logic [NUM_W-1:0] undo_number;
  logic [SLOT_W-1:0] slot_index;
  logic [NUM_W-1:0] fallback_trx_number;
  logic [NUM_W-1:0] fallback_undo_number;
  logic [NUM_W-1:0] view_low_limit;

  modport source(output valid, operation, trx_number, undo_number, slot_index,
                 fallback_trx_number, fallback_undo_number, view_low_limit,
                 input ready);
  modport sink(input valid, operation, trx_number, undo_number, slot_index,
               fallback_trx_number, fallback_undo_number, view_low_limit,
               output ready);
endinterface

interface pilt_out_if;
  import pilt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   stored_slot;
  logic [NUM_W-1:0]    limit_trx_number;
  logic [NUM_W-1:0]    limit_undo_number;
  logic [USED_W-1:0]   used_count;

  modport source(output valid, status, stored_slot, limit_trx_number,
                 limit_undo_number, used_count, input ready);
  modport sink(input valid, status, stored_slot, limit_trx_number,
               limit_undo_number, used_count, output ready);
endinterface

// ===== design/pilt_ram.sv =====
// pilt_ram: generic simple dual-port ram, one write and one registered read
// port. No dependencies.
`timescale 1ns / 1ps

module pilt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pilt_ctrl.sv =====
// pilt_ctrl: sequencer for store, release and limit query transactions.
// Depends on pilt_pkg; drives pilt_dp through pilt_cmd_t.
`timescale 1ns / 1ps

module pilt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pilt_pkg::pilt_stat_t stat,
  output pilt_pkg::pilt_cmd_t  cmd
);
  import pilt_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept   = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_STORE:   state_nxt = S_STORE;
          OP_RELEASE: state_nxt = S_RELEASE;
          OP_QUERY:   state_nxt = S_QSCAN;
          default:    state_nxt = S_FINISH;
        endcase
      end
      S_STORE: begin
        // lowest free slot wins; the last slot busy means the table is full
        cmd.store_try = 1'b1;
        if (stat.slot_free || stat.idx_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_RELEASE: begin
        cmd.rel   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_QSCAN: begin
        cmd.q_read = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_QDRAIN;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_QDRAIN: begin
        // last ram read is compared in this cycle
        state_nxt = S_QFALLBACK;
      end
      S_QFALLBACK: begin
        cmd.fallback = 1'b1;
        state_nxt    = S_QCLAMP;
      end
      S_QCLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/pilt_dp.sv =====
// pilt_dp: slot table (busy flags, count, pair ram), scan index, best-pair
// compare and result register. Depends on pilt_pkg and pilt_ram.
`timescale 1ns / 1ps

module pilt_dp #(
  parameter int SLOT_COUNT = pilt_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pilt_pkg::pilt_cmd_t           cmd,
  output pilt_pkg::pilt_stat_t          stat,
  input  logic [pilt_pkg::OP_W-1:0]     in_operation,
  input  logic [pilt_pkg::NUM_W-1:0]    in_trx_number,
  input  logic [pilt_pkg::NUM_W-1:0]    in_undo_number,
  input  logic [pilt_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic [pilt_pkg::NUM_W-1:0]    in_fallback_trx_number,
  input  logic [pilt_pkg::NUM_W-1:0]    in_fallback_undo_number,
  input  logic [pilt_pkg::NUM_W-1:0]    in_view_low_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pilt_pkg::STATUS_W-1:0] out_status,
  output logic [pilt_pkg::SLOT_W-1:0]   out_stored_slot,
  output logic [pilt_pkg::NUM_W-1:0]    out_limit_trx_number,
  output logic [pilt_pkg::NUM_W-1:0]    out_limit_undo_number,
  output logic [pilt_pkg::USED_W-1:0]   out_used_count
);
  import pilt_pkg::*;

  localparam int IDXW = $clog2(SLOT_COUNT);
  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int RW   = (IDXW > SLOT_W) ? IDXW : SLOT_W;

  // latched request
  op_t              op_r;
  logic [NUM_W-1:0] trx_r, undo_r, fb_trx_r, fb_undo_r, view_r;
  logic [SLOT_W-1:0] slot_r;

  logic [IDXW-1:0]       idx_r;
  logic [SLOT_COUNT-1:0] busy_r;
  logic [CW-1:0]         cnt_r;
  logic                  cmp_vld_r;
  logic [NUM_W-1:0]      best_trx_r, best_undo_r;
  status_t               res_status_r;
  logic [SLOT_W-1:0]     res_slot_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [NUM_W-1:0]      out_trx_r, out_undo_r;
  logic [USED_W-1:0]     out_used_r;

  logic [2*NUM_W-1:0] rd_data;
  logic [NUM_W-1:0]   rd_trx, rd_undo;
  logic               better;
  logic               slot_free;
  logic               store_hit;
  logic [RW-1:0]      rel_ext;
  logic [IDXW-1:0]    rel_idx;
  logic               rel_ok;

  assign slot_free = !busy_r[idx_r];
  assign store_hit = cmd.store_try && slot_free;

  assign rel_ext = RW'(slot_r);
  assign rel_idx = rel_ext[IDXW-1:0];
  assign rel_ok  = ({1'b0, rel_ext} < (RW + 1)'(SLOT_COUNT)) && busy_r[rel_idx];

  assign rd_trx  = rd_data[2*NUM_W-1:NUM_W];
  assign rd_undo = rd_data[NUM_W-1:0];
  assign better  = (rd_trx > best_trx_r) ||
                   ((rd_trx == best_trx_r) && (rd_undo >= best_undo_r));

  pilt_ram #(
    .WIDTH(2 * NUM_W),
    .DEPTH(SLOT_COUNT)
  ) u_pair_ram (
    .clk  (clk),
    .we   (store_hit),
    .waddr(idx_r),
    .wdata({trx_r, undo_r}),
    .raddr(idx_r),
    .rdata(rd_data)
  );

  // request payload, result scratch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_operation;
      trx_r        <= in_trx_number;
      undo_r       <= in_undo_number;
      slot_r       <= in_slot_index;
      fb_trx_r     <= in_fallback_trx_number;
      fb_undo_r    <= in_fallback_undo_number;
      view_r       <= in_view_low_limit;
      res_status_r <= ST_OK;
      res_slot_r   <= '0;
      best_trx_r   <= '0;
      best_undo_r  <= '0;
    end else begin
      if (store_hit) begin
        res_slot_r <= SLOT_W'(idx_r);
      end else if (cmd.store_try && stat.idx_last) begin
        res_status_r <= ST_FULL;
      end
      if (cmd.rel && !rel_ok) begin
        res_status_r <= ST_FREE;
      end
      if (cmp_vld_r && better) begin
        best_trx_r  <= rd_trx;
        best_undo_r <= rd_undo;
      end else if (cmd.fallback && (best_trx_r == '0)) begin
        best_trx_r  <= fb_trx_r;
        best_undo_r <= fb_undo_r;
      end else if (cmd.clamp && (best_trx_r >= view_r)) begin
        best_trx_r  <= view_r;
        best_undo_r <= '0;
      end
    end
  end

  // table control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      busy_r    <= '0;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        idx_r <= '0;
      end else if (cmd.scan_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (store_hit) begin
        busy_r[idx_r] <= 1'b1;
        cnt_r         <= cnt_r + 1'b1;
      end else if (cmd.rel && rel_ok) begin
        busy_r[rel_idx] <= 1'b0;
        cnt_r           <= cnt_r - 1'b1;
      end
      // ram data arrives in the cycle after its address, and so does its busy flag
      cmp_vld_r <= cmd.q_read && busy_r[idx_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_trx_r    <= (op_r == OP_QUERY) ? best_trx_r : '0;
      out_undo_r   <= (op_r == OP_QUERY) ? best_undo_r : '0;
      out_used_r   <= USED_W'(cnt_r);
    end
  end

  assign stat.op        = op_r;
  assign stat.idx_last  = (idx_r == IDXW'(SLOT_COUNT - 1));
  assign stat.slot_free = slot_free;
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_stored_slot       = out_slot_r;
  assign out_limit_trx_number  = out_trx_r;
  assign out_limit_undo_number = out_undo_r;
  assign out_used_count        = out_used_r;

endmodule

// ===== design/purge_inflight_limit_tracker_core.sv =====
// channel   dir   handshake        payload
// in_ch     in    valid / ready    operation, pair, slot index, fallback pair, view limit
// out_ch    out   valid / ready    status, stored slot, limit pair, used count
//
// one transaction at a time: store scans the busy flags for a free slot, release
// needs no scan, limit query does one pair ram read per slot
// the result register frees the input side: a new transaction is taken while a result waits
// a stalled result holds the sequencer in its final step until out_ch is taken
// rst_n (synchronous) clears busy flags and count at once; no clearing pass
// Depends on pilt_pkg, pilt_ifs, pilt_ctrl, pilt_dp.
`timescale 1ns / 1ps

module purge_inflight_limit_tracker_core #(
  parameter int SLOT_COUNT = pilt_pkg::SLOT_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pilt_in_if.sink    in_ch,
  pilt_out_if.source out_ch
);
  import pilt_pkg::*;

  pilt_cmd_t  cmd;
  pilt_stat_t stat;

  pilt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pilt_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_operation           (in_ch.operation),
    .in_trx_number          (in_ch.trx_number),
    .in_undo_number         (in_ch.undo_number),
    .in_slot_index          (in_ch.slot_index),
    .in_fallback_trx_number (in_ch.fallback_trx_number),
    .in_fallback_undo_number(in_ch.fallback_undo_number),
    .in_view_low_limit      (in_ch.view_low_limit),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_status             (out_ch.status),
    .out_stored_slot        (out_ch.stored_slot),
    .out_limit_trx_number   (out_ch.limit_trx_number),
    .out_limit_undo_number  (out_ch.limit_undo_number),
    .out_used_count         (out_ch.used_count)
  );

endmodule

// ===== design/pilt_checker.sv =====
// pilt_checker: port-level assertions for the tracker core, bound to it.
// Depends on pilt_pkg and purge_inflight_limit_tracker_core.
`timescale 1ns / 1ps

module pilt_checker #(
  parameter int SLOT_COUNT = pilt_pkg::SLOT_COUNT_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pilt_pkg::STATUS_W-1:0] out_status,
  input logic [pilt_pkg::SLOT_W-1:0]   out_stored_slot,
  input logic [pilt_pkg::NUM_W-1:0]    out_limit_trx_number,
  input logic [pilt_pkg::NUM_W-1:0]    out_limit_undo_number,
  input logic [pilt_pkg::USED_W-1:0]   out_used_count
);
  import pilt_pkg::*;

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_used_count) &&
                                $stable(out_limit_trx_number))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |->
      (out_used_count == USED_W'(SLOT_COUNT)) && (out_stored_slot == '0) &&
      (out_limit_trx_number == '0))
    else $error("table full reported with wrong fields");

  a_undo_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_limit_undo_number != '0) |->
      (out_status == ST_OK) && (out_stored_slot == '0))
    else $error("limit pair on a non-query result");

endmodule

bind purge_inflight_limit_tracker_core pilt_checker #(
  .SLOT_COUNT(SLOT_COUNT)
) u_pilt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_status           (out_ch.status),
  .out_stored_slot      (out_ch.stored_slot),
  .out_limit_trx_number (out_ch.limit_trx_number),
  .out_limit_undo_number(out_ch.limit_undo_number),
  .out_used_count       (out_ch.used_count)
);
